/* hdl/rv64d_pkg.sv */
// Package for the RV64 instruction decoder: operation and format codes.
// No dependencies.
`timescale 1ns / 1ps
package rv64d_pkg;

    typedef enum logic [7:0] {
        K_NONE = 8'd0, K_LDS, K_LD, K_FPLD, K_ST, K_FPST,
        K_FADD, K_FSUB, K_FMUL, K_FDIV, K_FSGNJ, K_FMINMAX, K_FCVTFF, K_FSQRT,
        K_FCMP, K_FCVTFG, K_FCVTGF, K_FMVFG, K_FMVGF,
        K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_BSETI, K_BCLRI,
        K_BINVI, K_CLZ, K_CTZ, K_CPOP, K_SEXTB, K_SEXTH, K_SRLI, K_ORCB, K_SRAI,
        K_BEXTI, K_RORI, K_REV8,
        K_ADDIW, K_SLLIW, K_SLLIUW, K_CLZW, K_CTZW, K_CPOPW, K_SRLIW, K_SRAIW,
        K_RORIW,
        K_ADD, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_OR, K_AND, K_MUL, K_MULH,
        K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU, K_SUB, K_SRA, K_CLMUL,
        K_CLMULR, K_CLMULH, K_MIN, K_MINU, K_MAX, K_MAXU, K_SH1ADD, K_SH2ADD,
        K_SH3ADD, K_BSET, K_ROL, K_ROR, K_BINV, K_XNOR, K_ORN, K_ANDN, K_BCLR,
        K_BEXT,
        K_ADDW, K_SLLW, K_SRLW, K_MULW, K_DIVW, K_DIVUW, K_REMW, K_REMUW, K_SUBW,
        K_SRAW, K_ADDUW, K_ZEXTH, K_SH1ADDUW, K_SH2ADDUW, K_SH3ADDUW, K_ROLW,
        K_RORW,
        K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
        K_PRIV, K_CSRRW, K_CSRRS, K_CSRRC, K_CSRRWI, K_CSRRSI, K_CSRRCI,
        K_AMOADD, K_AMOSWAP, K_LR, K_SC, K_AMOXOR, K_AMOAND, K_AMOOR, K_AMOMIN,
        K_AMOMAX, K_AMOMINU, K_AMOMAXU,
        K_JALR, K_LUI, K_FENCE, K_AUIPC, K_FMADD, K_FMSUB, K_FNMSUB, K_FNMADD,
        K_TRAP, K_JAL
    } t_op;

    typedef enum logic [5:0] {
        G_NONE = 6'd0, G_FPR2GPR, G_GPR2FPR, G_CSR, G_CSRI, G_CJR, G_CMOV,
        G_CJALR, G_CADD, G_CADDI16SP, G_CLUI, G_CS, G_CBSHIFT, G_CBANDI, G_I,
        G_FI, G_U, G_S, G_FS, G_R, G_FR, G_B, G_J, G_CADDI4SPN, G_CFLD, G_CLW,
        G_CLD, G_CFSD, G_CSW, G_CSD, G_CISIMM, G_CLI, G_CJ, G_CB, G_CIUIMM,
        G_CFLDSP, G_CLWSP, G_CLDSP, G_CFSDSP, G_CSWSP, G_CSDSP
    } t_fmt;

    // Decode result as carried from the decode logic to the output register.
    typedef struct packed {
        t_op        op;
        t_fmt       fmt;
        logic [3:0] width;
        logic       comp;
        logic       bad;
        logic       amo;
        logic       hole;
    } t_dec;

    // Major opcodes, bits 6:2.
    localparam logic [4:0] OPC_LOAD   = 5'o00, OPC_LOADFP = 5'o01, OPC_FENCE = 5'o03,
                           OPC_OPIMM  = 5'o04, OPC_AUIPC  = 5'o05, OPC_OPIMM32 = 5'o06,
                           OPC_STORE  = 5'o10, OPC_STOREFP = 5'o11, OPC_AMO  = 5'o13,
                           OPC_OP     = 5'o14, OPC_LUI    = 5'o15, OPC_OP32  = 5'o16,
                           OPC_MADD   = 5'o20, OPC_MSUB   = 5'o21, OPC_NMSUB = 5'o22,
                           OPC_NMADD  = 5'o23, OPC_OPFP   = 5'o24, OPC_BRANCH = 5'o30,
                           OPC_JALR   = 5'o31, OPC_TRAP   = 5'o32, OPC_JAL   = 5'o33,
                           OPC_SYSTEM = 5'o34;

endpackage

/* hdl/rv64_instruction_decoder_top.sv */
// RV64 instruction decoder top level: input register, decode logic, output register.
// Depends on rv64d_pkg.
`timescale 1ns / 1ps
// Classifies one instruction word per item: operation number, operand format,
// access width and the compressed / illegal / storing-atomic / empty-slot flags.
// Each item passes the input register, then the result register, and one item is
// taken every cycle; the only thing that holds an item back is a stalled output
// with the input stage full. Words whose bits 1:0 are not 3 decode as 16-bit
// forms from bits 15:0. Illegal and empty-slot results carry op_id zero but keep
// the format and width set along the decode path. The block holds no state
// beyond its two pipeline registers.
module rv64_instruction_decoder_top
    import rv64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instr_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] op_id, [13:8] format_id, [17:14] access_width, [18] is_compressed,
    // [19] illegal, [20] amo_store, [21] empty_slot, [23:22] zero
    output logic [23:0] m_axis_tdata
);

    logic        r_in_vld;
    logic [31:0] r_in_word;
    logic        r_out_vld;
    t_dec        r_out;
    t_dec        n_dec;
    logic        w_adv;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (w_adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in_word <= s_axis_tdata;
        if (w_adv && r_in_vld) r_out <= n_dec;
    end

    // Decode logic.
    always_comb begin
        logic [31:0] w;
        logic [2:0]  f3;
        logic [4:0]  hi, lo, opc, rd;
        logic [6:0]  f7;
        logic [4:0]  csel;
        logic [2:0]  s3;
        t_dec        d;
        w    = r_in_word;
        f3   = w[14:12];
        hi   = w[31:27];
        lo   = w[24:20];
        f7   = w[31:25];
        opc  = w[6:2];
        rd   = w[11:7];
        csel = {w[1:0], w[15:13]};
        s3   = 3'd0;
        d    = '0;
        d.comp = (w[1:0] != 2'b11);
        if (!d.comp) begin
            unique case (opc)
                OPC_LOAD: begin
                    d.fmt = G_I;
                    case (f3)
                        3'd0: begin d.op = K_LDS; d.width = 4'd1; end
                        3'd1: begin d.op = K_LDS; d.width = 4'd2; end
                        3'd2: begin d.op = K_LDS; d.width = 4'd4; end
                        3'd3: begin d.op = K_LD;  d.width = 4'd8; end
                        3'd4: begin d.op = K_LD;  d.width = 4'd1; end
                        3'd5: begin d.op = K_LD;  d.width = 4'd2; end
                        3'd6: begin d.op = K_LD;  d.width = 4'd4; end
                        default: d.bad = 1'b1;
                    endcase
                end
                OPC_LOADFP: begin
                    d.fmt = G_FI;
                    if (f3 == 3'b010) begin d.op = K_FPLD; d.width = 4'd4; end
                    else if (f3 == 3'b011) begin d.op = K_FPLD; d.width = 4'd8; end
                    else d.bad = 1'b1;
                end
                OPC_FENCE: d.op = K_FENCE;
                OPC_OPIMM: begin
                    d.fmt = G_I;
                    case (f3)
                        3'd0: d.op = K_ADDI;
                        3'd2: d.op = K_SLTI;
                        3'd3: d.op = K_SLTIU;
                        3'd4: d.op = K_XORI;
                        3'd6: d.op = K_ORI;
                        3'd7: d.op = K_ANDI;
                        3'd1: begin
                            case (hi)
                                5'd0:  d.op = K_SLLI;
                                5'd5:  d.op = K_BSETI;
                                5'd9:  d.op = K_BCLRI;
                                5'd13: d.op = K_BINVI;
                                5'd12: begin
                                    case (lo)
                                        5'd0: d.op = K_CLZ;
                                        5'd1: d.op = K_CTZ;
                                        5'd2: d.op = K_CPOP;
                                        5'd4: d.op = K_SEXTB;
                                        5'd5: d.op = K_SEXTH;
                                        default: d.bad = 1'b1;
                                    endcase
                                end
                                default: d.bad = 1'b1;
                            endcase
                        end
                        default: begin
                            case (hi)
                                5'd0:  d.op = K_SRLI;
                                5'd5:  d.op = K_ORCB;
                                5'd8:  d.op = K_SRAI;
                                5'd9:  d.op = K_BEXTI;
                                5'd12: d.op = K_RORI;
                                5'd13: d.op = K_REV8;
                                default: d.bad = 1'b1;
                            endcase
                        end
                    endcase
                end
                OPC_AUIPC: begin d.fmt = G_U; d.op = K_AUIPC; end
                OPC_OPIMM32: begin
                    d.fmt = G_I;
                    if (f3 == 3'd0) d.op = K_ADDIW;
                    else if (f3 == 3'd1) begin
                        if (hi == 5'd0) d.op = K_SLLIW;
                        else if (hi == 5'd1) d.op = K_SLLIUW;
                        else if (hi == 5'd12) begin
                            if (lo == 5'd0) d.op = K_CLZW;
                            else if (lo == 5'd1) d.op = K_CTZW;
                            else if (lo == 5'd2) d.op = K_CPOPW;
                            else d.bad = 1'b1;
                        end else d.hole = 1'b1;
                    end else if (f3 == 3'd5) begin
                        if (hi == 5'd0) d.op = K_SRLIW;
                        else if (hi == 5'd8) d.op = K_SRAIW;
                        else if (hi == 5'd12) d.op = K_RORIW;
                        else d.bad = 1'b1;
                    end else d.bad = 1'b1;
                end
                OPC_STORE: begin
                    d.fmt = G_S;
                    if (!f3[2]) begin d.op = K_ST; d.width = 4'd1 << f3[1:0]; end
                    else d.hole = 1'b1;
                end
                OPC_STOREFP: begin
                    d.fmt = G_FS;
                    if (f3 == 3'b010) begin d.op = K_FPST; d.width = 4'd4; end
                    else if (f3 == 3'b011) begin d.op = K_FPST; d.width = 4'd8; end
                    else d.bad = 1'b1;
                end
                OPC_AMO: begin
                    d.fmt = G_R;
                    if (!f3[2]) d.width = 4'd1 << f3[1:0];
                    case (hi)
                        5'h00: d.op = K_AMOADD;
                        5'h01: d.op = K_AMOSWAP;
                        5'h02: d.op = K_LR;
                        5'h03: d.op = K_SC;
                        5'h04: d.op = K_AMOXOR;
                        5'h0c: d.op = K_AMOAND;
                        5'h08: d.op = K_AMOOR;
                        5'h10: d.op = K_AMOMIN;
                        5'h14: d.op = K_AMOMAX;
                        5'h18: d.op = K_AMOMINU;
                        5'h1c: d.op = K_AMOMAXU;
                        default: d.hole = 1'b1;
                    endcase
                    d.amo = !d.hole && (d.op != K_LR);
                end
                OPC_OP: begin
                    d.fmt = G_R;
                    case ({f7, f3})
                        {7'd0, 3'd0}: d.op = K_ADD;
                        {7'd0, 3'd1}: d.op = K_SLL;
                        {7'd0, 3'd2}: d.op = K_SLT;
                        {7'd0, 3'd3}: d.op = K_SLTU;
                        {7'd0, 3'd4}: d.op = K_XOR;
                        {7'd0, 3'd5}: d.op = K_SRL;
                        {7'd0, 3'd6}: d.op = K_OR;
                        {7'd0, 3'd7}: d.op = K_AND;
                        {7'd1, 3'd0}: d.op = K_MUL;
                        {7'd1, 3'd1}: d.op = K_MULH;
                        {7'd1, 3'd2}: d.op = K_MULHSU;
                        {7'd1, 3'd3}: d.op = K_MULHU;
                        {7'd1, 3'd4}: d.op = K_DIV;
                        {7'd1, 3'd5}: d.op = K_DIVU;
                        {7'd1, 3'd6}: d.op = K_REM;
                        {7'd1, 3'd7}: d.op = K_REMU;
                        {7'd32, 3'd0}: d.op = K_SUB;
                        {7'd32, 3'd5}: d.op = K_SRA;
                        {7'd5, 3'd1}: d.op = K_CLMUL;
                        {7'd5, 3'd2}: d.op = K_CLMULR;
                        {7'd5, 3'd3}: d.op = K_CLMULH;
                        {7'd5, 3'd4}: d.op = K_MIN;
                        {7'd5, 3'd5}: d.op = K_MINU;
                        {7'd5, 3'd6}: d.op = K_MAX;
                        {7'd5, 3'd7}: d.op = K_MAXU;
                        {7'd16, 3'd2}: d.op = K_SH1ADD;
                        {7'd16, 3'd4}: d.op = K_SH2ADD;
                        {7'd16, 3'd6}: d.op = K_SH3ADD;
                        {7'd20, 3'd1}: d.op = K_BSET;
                        {7'd48, 3'd1}: d.op = K_ROL;
                        {7'd48, 3'd5}: d.op = K_ROR;
                        {7'd52, 3'd1}: d.op = K_BINV;
                        {7'd32, 3'd4}: d.op = K_XNOR;
                        {7'd32, 3'd6}: d.op = K_ORN;
                        {7'd32, 3'd7}: d.op = K_ANDN;
                        {7'd36, 3'd1}: d.op = K_BCLR;
                        {7'd36, 3'd5}: d.op = K_BEXT;
                        default: d.bad = 1'b1;
                    endcase
                end
                OPC_LUI: begin d.fmt = G_U; d.op = K_LUI; end
                OPC_OP32: begin
                    d.fmt = G_R;
                    case ({f7, f3})
                        {7'd0, 3'd0}: d.op = K_ADDW;
                        {7'd0, 3'd1}: d.op = K_SLLW;
                        {7'd0, 3'd5}: d.op = K_SRLW;
                        {7'd1, 3'd0}: d.op = K_MULW;
                        {7'd1, 3'd4}: d.op = K_DIVW;
                        {7'd1, 3'd5}: d.op = K_DIVUW;
                        {7'd1, 3'd6}: d.op = K_REMW;
                        {7'd1, 3'd7}: d.op = K_REMUW;
                        {7'd32, 3'd0}: d.op = K_SUBW;
                        {7'd32, 3'd5}: d.op = K_SRAW;
                        {7'd4, 3'd0}: d.op = K_ADDUW;
                        {7'd4, 3'd4}: d.op = K_ZEXTH;
                        {7'd16, 3'd2}: d.op = K_SH1ADDUW;
                        {7'd16, 3'd4}: d.op = K_SH2ADDUW;
                        {7'd16, 3'd6}: d.op = K_SH3ADDUW;
                        {7'd48, 3'd1}: d.op = K_ROLW;
                        {7'd48, 3'd5}: d.op = K_RORW;
                        default: d.bad = 1'b1;
                    endcase
                end
                OPC_MADD:  begin d.fmt = G_FR; d.op = K_FMADD; end
                OPC_MSUB:  begin d.fmt = G_FR; d.op = K_FMSUB; end
                OPC_NMSUB: begin d.fmt = G_FR; d.op = K_FNMSUB; end
                OPC_NMADD: begin d.fmt = G_FR; d.op = K_FNMADD; end
                OPC_OPFP: begin
                    d.fmt = G_FR;
                    case (hi)
                        5'd0:  d.op = K_FADD;
                        5'd1:  d.op = K_FSUB;
                        5'd2:  d.op = K_FMUL;
                        5'd3:  d.op = K_FDIV;
                        5'd4:  d.op = K_FSGNJ;
                        5'd5:  d.op = K_FMINMAX;
                        5'd8:  d.op = K_FCVTFF;
                        5'd11: d.op = K_FSQRT;
                        5'd20: begin d.fmt = G_FPR2GPR; d.op = K_FCMP; end
                        5'd24: begin d.fmt = G_FPR2GPR; d.op = K_FCVTFG; end
                        5'd26: begin d.fmt = G_GPR2FPR; d.op = K_FCVTGF; end
                        5'd28: begin d.fmt = G_FPR2GPR; d.op = K_FMVFG; end
                        5'd30: begin d.fmt = G_GPR2FPR; d.op = K_FMVGF; end
                        default: d.bad = 1'b1;
                    endcase
                end
                OPC_BRANCH: begin
                    d.fmt = G_B;
                    case (f3)
                        3'd0: d.op = K_BEQ;
                        3'd1: d.op = K_BNE;
                        3'd4: d.op = K_BLT;
                        3'd5: d.op = K_BGE;
                        3'd6: d.op = K_BLTU;
                        3'd7: d.op = K_BGEU;
                        default: d.hole = 1'b1;
                    endcase
                end
                OPC_JALR: begin d.fmt = G_I; d.op = K_JALR; end
                OPC_TRAP: d.op = K_TRAP;
                OPC_JAL:  begin d.fmt = G_J; d.op = K_JAL; end
                OPC_SYSTEM: begin
                    case (f3)
                        3'd0: d.op = K_PRIV;
                        3'd1: begin d.fmt = G_CSR;  d.op = K_CSRRW; end
                        3'd2: begin d.fmt = G_CSR;  d.op = K_CSRRS; end
                        3'd3: begin d.fmt = G_CSR;  d.op = K_CSRRC; end
                        3'd5: begin d.fmt = G_CSRI; d.op = K_CSRRWI; end
                        3'd6: begin d.fmt = G_CSRI; d.op = K_CSRRSI; end
                        3'd7: begin d.fmt = G_CSRI; d.op = K_CSRRCI; end
                        default: d.hole = 1'b1;
                    endcase
                end
                default: d.bad = 1'b1;
            endcase
        end else begin
            unique case (csel)
                5'o00: begin d.fmt = G_CADDI4SPN; d.op = K_ADDI; end
                5'o01: begin d.fmt = G_CFLD; d.op = K_FPLD; d.width = 4'd8; end
                5'o02: begin d.fmt = G_CLW;  d.op = K_LDS;  d.width = 4'd4; end
                5'o03: begin d.fmt = G_CLD;  d.op = K_LD;   d.width = 4'd8; end
                5'o05: begin d.fmt = G_CFSD; d.op = K_FPST; d.width = 4'd8; end
                5'o06: begin d.fmt = G_CSW;  d.op = K_ST;   d.width = 4'd4; end
                5'o07: begin d.fmt = G_CSD;  d.op = K_ST;   d.width = 4'd8; end
                5'o10: begin d.fmt = G_CISIMM; d.op = K_ADDI; end
                5'o11: begin d.fmt = G_CISIMM; d.op = K_ADDIW; end
                5'o12: begin d.fmt = G_CLI; d.op = K_ADDI; end
                5'o13: begin
                    // rd of sp is ADDI16SP; every other rd, zero too, is LUI
                    if (rd == 5'd2) begin d.fmt = G_CADDI16SP; d.op = K_ADDI; end
                    else begin d.fmt = G_CLUI; d.op = K_LUI; end
                end
                5'o14: begin
                    case (w[11:10])
                        2'd0: begin d.fmt = G_CBSHIFT; d.op = K_SRLI; end
                        2'd1: begin d.fmt = G_CBSHIFT; d.op = K_SRAI; end
                        2'd2: begin d.fmt = G_CBANDI;  d.op = K_ANDI; end
                        default: begin
                            s3 = {w[12], w[6:5]};
                            d.fmt = G_CS;
                            case (s3)
                                3'd0: d.op = K_SUB;
                                3'd1: d.op = K_XOR;
                                3'd2: d.op = K_OR;
                                3'd3: d.op = K_AND;
                                3'd4: d.op = K_SUBW;
                                3'd5: d.op = K_ADDW;
                                default: begin d.fmt = G_NONE; d.hole = 1'b1; end
                            endcase
                        end
                    endcase
                end
                5'o15: begin d.fmt = G_CJ; d.op = K_JAL; end
                5'o16: begin d.fmt = G_CB; d.op = K_BEQ; end
                5'o17: begin d.fmt = G_CB; d.op = K_BNE; end
                5'o20: begin d.fmt = G_CIUIMM; d.op = K_SLLI; end
                5'o21: begin d.fmt = G_CFLDSP; d.op = K_FPLD; d.width = 4'd8; end
                5'o22: begin d.fmt = G_CLWSP;  d.op = K_LDS;  d.width = 4'd4; end
                5'o23: begin d.fmt = G_CLDSP;  d.op = K_LD;   d.width = 4'd8; end
                5'o24: begin
                    case ({w[12], rd != 5'd0, w[6:2] != 5'd0})
                        3'b010: begin d.fmt = G_CJR;   d.op = K_JALR; end
                        3'b011: begin d.fmt = G_CMOV;  d.op = K_ADD; end
                        3'b110: begin d.fmt = G_CJALR; d.op = K_JALR; end
                        3'b111: begin d.fmt = G_CADD;  d.op = K_ADD; end
                        default: d.bad = 1'b1;
                    endcase
                end
                5'o25: begin d.fmt = G_CFSDSP; d.op = K_FPST; d.width = 4'd8; end
                5'o26: begin d.fmt = G_CSWSP;  d.op = K_ST;   d.width = 4'd4; end
                5'o27: begin d.fmt = G_CSDSP;  d.op = K_ST;   d.width = 4'd8; end
                default: d.bad = 1'b1;
            endcase
        end
        if (d.bad || d.hole) begin
            d.op  = K_NONE;
            d.amo = 1'b0;
        end
        n_dec = d;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out.hole, r_out.amo, r_out.bad, r_out.comp,
                            r_out.width, r_out.fmt, r_out.op};

`ifndef SYNTH
    // A stalled result must not change under the consumer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // No result is both illegal and an empty slot, and neither names an op.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.bad && r_out.hole) &&
            ((r_out.bad || r_out.hole) ? r_out.op == K_NONE : 1'b1))
        else $error("inconsistent flags");
    // Storing atomics only come from the wide AMO opcode.
    a_amo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.amo |-> !r_out.comp && r_out.fmt == G_R)
        else $error("amo flag outside atomics");
`endif

endmodule
